### rtl/stack_with_value_delete_core_macros.svh
// Assertion macros for the stack-with-delete RTL.
// Included by swd_dpath, which checks its own control invariants.
`ifndef STACK_WITH_VALUE_DELETE_CORE_MACROS_SVH
`define STACK_WITH_VALUE_DELETE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/swd_pkg.sv
// Types and codes for the stack-with-delete block.
// Used by swd_ctrl, swd_dpath and stack_with_value_delete_core; no dependencies.
`default_nettype none

package swd_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_DELETE  = 2'd1,
    MODE_DISPLAY = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RES_PUSHED   = 3'd0,
    RES_DELETED  = 3'd1,
    RES_EMPTY    = 3'd2,
    RES_NOTFOUND = 3'd3,
    RES_FULL     = 3'd4,
    RES_ELEMENT  = 3'd5
  } rslt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_SRCH,
    ST_SHIFT,
    ST_EMIT,
    ST_DISP
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic               last;
  } out_t;

  typedef struct packed {
    logic  load;
    logic  push_wr;
    logic  ptr_top;
    logic  ptr_dec;
    logic  ptr_inc;
    logic  shift_wr;
    logic  cnt_dec;
    logic  set_status;
    rslt_t code;
    logic  emit_single;
    logic  emit_elem;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  match;
    logic  ptr_zero;
    logic  at_top;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/swd_ctrl.sv
// Controller FSM for the stack-with-delete block.
// Depends on swd_pkg; drives swd_dpath through ctrl_cmd_t.
`default_nettype none

module swd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swd_pkg::dp_sts_t   sts,
  output swd_pkg::ctrl_cmd_t      cmd
);

  swd_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      swd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = swd_pkg::ST_OP;
        end
      end
      swd_pkg::ST_OP: begin
        case (sts.mode)
          swd_pkg::MODE_PUSH: begin
            cmd.set_status = 1'b1;
            if (sts.full) begin
              cmd.code = swd_pkg::RES_FULL;
            end else begin
              cmd.push_wr = 1'b1;
              cmd.code    = swd_pkg::RES_PUSHED;
            end
            state_nxt = swd_pkg::ST_EMIT;
          end
          swd_pkg::MODE_DELETE: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.code       = swd_pkg::RES_EMPTY;
              state_nxt      = swd_pkg::ST_EMIT;
            end else begin
              cmd.ptr_top = 1'b1;
              state_nxt   = swd_pkg::ST_SRCH;
            end
          end
          swd_pkg::MODE_DISPLAY: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.code       = swd_pkg::RES_EMPTY;
              state_nxt      = swd_pkg::ST_EMIT;
            end else begin
              cmd.ptr_top = 1'b1;
              state_nxt   = swd_pkg::ST_DISP;
            end
          end
          default: begin
            state_nxt = swd_pkg::ST_IDLE;
          end
        endcase
      end
      swd_pkg::ST_SRCH: begin
        if (sts.match) begin
          if (sts.at_top) begin
            cmd.cnt_dec    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.code       = swd_pkg::RES_DELETED;
            state_nxt      = swd_pkg::ST_EMIT;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = swd_pkg::ST_SHIFT;
          end
        end else if (sts.ptr_zero) begin
          cmd.set_status = 1'b1;
          cmd.code       = swd_pkg::RES_NOTFOUND;
          state_nxt      = swd_pkg::ST_EMIT;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      swd_pkg::ST_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (sts.at_top) begin
          cmd.cnt_dec    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.code       = swd_pkg::RES_DELETED;
          state_nxt      = swd_pkg::ST_EMIT;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      swd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = swd_pkg::ST_IDLE;
        end
      end
      swd_pkg::ST_DISP: begin
        if (sts.out_free) begin
          cmd.emit_elem = 1'b1;
          if (sts.ptr_zero) begin
            state_nxt = swd_pkg::ST_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = swd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/swd_dpath.sv
// Datapath for the stack-with-delete block: entry memory, count, pointer, output register.
// Depends on swd_pkg and stack_with_value_delete_core_macros.svh; driven by swd_ctrl.
`default_nettype none
`include "stack_with_value_delete_core_macros.svh"

module swd_dpath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swd_pkg::in_t       in_data,
  input  wire swd_pkg::ctrl_cmd_t cmd,
  output swd_pkg::dp_sts_t        sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output swd_pkg::out_t           out_data
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int ELW = (WORD_BITS > 32) ? WORD_BITS : 32;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] word_r;
  swd_pkg::mode_t       mode_r;
  logic [CW-1:0]        count_r;
  logic [AW-1:0]        ptr_r;
  swd_pkg::rslt_t       code_r;
  logic                 out_valid_r;
  swd_pkg::out_t        out_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        top_idx;
  logic [ELW-1:0]       elem_ext;
  logic                 out_free;

  assign top_idx  = AW'(count_r - 1'b1);
  assign out_free = !out_valid_r || out_ready;
  assign elem_ext = ELW'(rd_data_r);

  always_comb begin
    wr_en   = cmd.push_wr || cmd.shift_wr;
    wr_addr = cmd.push_wr ? count_r[AW-1:0] : AW'(ptr_r - 1'b1);
    wr_data = cmd.push_wr ? word_r : rd_data_r;
    rd_en   = cmd.ptr_top || cmd.ptr_dec || cmd.ptr_inc;
    if (cmd.ptr_top) begin
      rd_addr = top_idx;
    end else if (cmd.ptr_inc) begin
      rd_addr = AW'(ptr_r + 1'b1);
    end else begin
      rd_addr = AW'(ptr_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= swd_pkg::mode_t'(in_data.mode);
      word_r <= WORD_BITS'($unsigned(in_data.value));
    end
    if (rd_en) begin
      ptr_r <= rd_addr;
    end
    if (cmd.set_status) begin
      code_r <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push_wr) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_elem) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_r.status  <= code_r;
      out_r.element <= '0;
      out_r.last    <= 1'b1;
    end else if (cmd.emit_elem) begin
      out_r.status  <= swd_pkg::RES_ELEMENT;
      out_r.element <= elem_ext[31:0];
      out_r.last    <= (ptr_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.mode     = mode_r;
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.match    = (rd_data_r == word_r);
  assign sts.ptr_zero = (ptr_r == '0);
  assign sts.at_top   = (ptr_r == top_idx);
  assign sts.out_free = out_free;

  `SWD_ASSERT_NOW(a_emit_slot, clk, rst_n, cmd.emit_single || cmd.emit_elem, out_free, "emit into occupied output register")
  `SWD_ASSERT_NOW(a_push_room, clk, rst_n, cmd.push_wr, count_r < CW'(DEPTH), "push write while full")
  `SWD_ASSERT_NEXT(a_push_count, clk, rst_n, cmd.push_wr, count_r == $past(count_r) + 1'b1, "count did not advance on push")
  `SWD_ASSERT_NOW(a_shift_range, clk, rst_n, cmd.shift_wr, (ptr_r != '0) && (CW'(ptr_r) < count_r), "compaction outside held entries")

endmodule

`default_nettype wire

### rtl/stack_with_value_delete_core.sv
// Bounded LIFO stack of signed words with delete-by-value and display.
// Input channel in_valid/in_ready/in_data carries mode and value; result channel
// out_valid/out_ready/out_data carries status, element and last (last marks the final
// result of an item). Push and any empty or full result: one result, its status set in
// the operation state and registered out from the emit state. Delete, found or not: reads
// one entry per cycle from the top, then moves each entry above the match down one place
// per cycle; its result follows the search and the moves. Display: one result per cycle
// while the receiver takes them, from top to bottom, after the operation state reads the
// top entry. The entry memory, one read and one write per cycle, sets the pace of these
// walks. One item is worked at a time; the next input transfer is taken as soon as the
// previous item's last result sits in the output register. A stalled receiver holds the
// output register and pauses the walk. Synchronous reset empties the stack and the output
// register; entry contents stay unspecified and need no clearing pass since only held
// entries are ever read. Unused mode three is dropped with no result.
`default_nettype none

module stack_with_value_delete_core #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire swd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output swd_pkg::out_t      out_data
);

  swd_pkg::ctrl_cmd_t cmd;
  swd_pkg::dp_sts_t   sts;

  swd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swd_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
